/* design/ehas_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the embedded-controller host access sequencer.
// No dependencies; used by ec_host_access_sequencer_top.
package ehas_pkg;

    // Wait counter width, saturating
    localparam int TICK_W = 16;

    // Stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_COMMAND_PORT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DATA_PORT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_READ_OPCODE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WRITE_OPCODE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_IBF_MASK     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_OBF_MASK     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOGGLE_MASK  = 3'd7;

    // Configuration reset values
    localparam logic [15:0] RST_COMMAND_PORT = 16'd102;
    localparam logic [15:0] RST_DATA_PORT    = 16'd98;
    localparam logic [7:0]  RST_READ_OPCODE  = 8'h80;
    localparam logic [7:0]  RST_WRITE_OPCODE = 8'h81;
    localparam logic [7:0]  RST_IBF_MASK     = 8'h02;
    localparam logic [7:0]  RST_OBF_MASK     = 8'h01;
    localparam logic [15:0] RST_TIMEOUT      = 16'd10;
    localparam logic [7:0]  RST_TOGGLE_MASK  = 8'h01;

    // Request codes
    localparam logic [2:0] REQ_READ   = 3'd0;
    localparam logic [2:0] REQ_WRITE  = 3'd1;
    localparam logic [2:0] REQ_TOGGLE = 3'd2;
    localparam logic [2:0] REQ_TEST   = 3'd3;
    localparam logic [2:0] REQ_RESP   = 3'd4;
    localparam logic [2:0] REQ_TICK   = 3'd5;

    // Operation kinds held during a request
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_TOGGLE = 2'd2;
    localparam logic [1:0] OP_TEST   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_PORT_RD = 2'd0;
    localparam logic [1:0] KIND_PORT_WR = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    // Completion status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_BUS_ERR = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  rval;
        logic        bit_state;
        logic [1:0]  status;
    } result_t;

    // Results caused by one input: one or two items
    typedef struct packed {
        result_t res0;
        result_t res1;
        logic    two;
    } run_t;

endpackage

/* design/ec_host_access_sequencer_top.sv */
`timescale 1ns / 1ps
// Host-side sequencer for embedded-controller byte access over a command/status
// and a data I/O port. Depends on ehas_pkg.
//
//  Channel  | Direction | Transfer
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | request, port read response or tick
//  m_axis   | out       | port read request, port write or completion
//  cfg      | in        | register write, one per cycle, no handshake
//
//  An input transfer is processed in the cycle it is accepted; its results, if
//  any (one or two), go into a two-entry run queue and leave one per cycle
//  while m_tready is high.
//  Sustained rate while m_tready is high: one input per cycle for inputs with no
//  or one result; inputs giving two each are held back by the single output port.
//  s_tready is low only while the run queue holds two runs; a stalled m_axis
//  never blocks the input before that.
//  rst_n clears the sequence state and the run queue and resets the configuration.
module ec_host_access_sequencer_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [ehas_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ehas_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ec_reg[7:0], write_value[15:8], port_data[23:16], bus_error[24], zero
    input  logic [ehas_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type[2:0]
    input  logic [ehas_pkg::S_TUSER_W-1:0]      s_tuser,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // port_addr[15:0], port_wdata[23:16], read_value[31:24], bit_state[32],
    // status[34:33], zero
    output logic [ehas_pkg::M_TDATA_W-1:0]      m_tdata,
    // out_kind[1:0]
    output logic [ehas_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast
);

    localparam int CMP_W = (ehas_pkg::TICK_W > 16) ? ehas_pkg::TICK_W : 16;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RD_CMD,
        PH_RD_REG,
        PH_RD_OBF,
        PH_RD_DATA,
        PH_WR_CMD,
        PH_WR_REG,
        PH_WR_VAL
    } phase_t;

    // Configuration registers
    logic [15:0] command_port_reg;
    logic [15:0] data_port_reg;
    logic [7:0]  read_opcode_reg;
    logic [7:0]  write_opcode_reg;
    logic [7:0]  ibf_mask_reg;
    logic [7:0]  obf_mask_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  toggle_mask_reg;

    // Sequence state
    phase_t                      phase_reg, phase_next;
    logic [1:0]                  op_kind_reg, op_kind_next;
    logic [7:0]                  target_reg_reg, target_reg_next;
    logic [7:0]                  pending_reg, pending_next;
    logic [7:0]                  fetched_reg, fetched_next;
    logic [ehas_pkg::TICK_W-1:0] wait_ticks_reg, wait_ticks_next;

    // Run queue
    ehas_pkg::run_t run_q [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           sub_reg;

    // Input fields
    logic [2:0] req_type;
    logic [7:0] ec_reg;
    logic [7:0] write_value;
    logic [7:0] port_data;
    logic       bus_error;

    logic           in_xfer;
    logic           push;
    logic           pop;
    logic [1:0]     n_res;
    ehas_pkg::run_t run_new;
    ehas_pkg::result_t head_res;
    logic           head_last;

    // Poll decode
    logic       want_set;
    logic [7:0] poll_mask;
    logic       poll_met;
    logic       wait_expired;

    assign req_type    = s_tuser[2:0];
    assign ec_reg      = s_tdata[7:0];
    assign write_value = s_tdata[15:8];
    assign port_data   = s_tdata[23:16];
    assign bus_error   = s_tdata[24];

    function automatic ehas_pkg::result_t mk_res(
        input logic [1:0]  kind,
        input logic [15:0] addr,
        input logic [7:0]  wdata,
        input logic [7:0]  rval,
        input logic        bit_state,
        input logic [1:0]  status
    );
        ehas_pkg::result_t r;
        r.kind      = kind;
        r.addr      = addr;
        r.wdata     = wdata;
        r.rval      = rval;
        r.bit_state = bit_state;
        r.status    = status;
        return r;
    endfunction

    // All toggle-mask bits set in a byte
    function automatic logic mask_set(input logic [7:0] v, input logic [7:0] m);
        return (v & m) == m;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_port_reg <= ehas_pkg::RST_COMMAND_PORT;
            data_port_reg    <= ehas_pkg::RST_DATA_PORT;
            read_opcode_reg  <= ehas_pkg::RST_READ_OPCODE;
            write_opcode_reg <= ehas_pkg::RST_WRITE_OPCODE;
            ibf_mask_reg     <= ehas_pkg::RST_IBF_MASK;
            obf_mask_reg     <= ehas_pkg::RST_OBF_MASK;
            timeout_reg      <= ehas_pkg::RST_TIMEOUT;
            toggle_mask_reg  <= ehas_pkg::RST_TOGGLE_MASK;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ehas_pkg::CFG_COMMAND_PORT: command_port_reg <= cfg_wdata[15:0];
                ehas_pkg::CFG_DATA_PORT:    data_port_reg    <= cfg_wdata[15:0];
                ehas_pkg::CFG_READ_OPCODE:  read_opcode_reg  <= cfg_wdata[7:0];
                ehas_pkg::CFG_WRITE_OPCODE: write_opcode_reg <= cfg_wdata[7:0];
                ehas_pkg::CFG_IBF_MASK:     ibf_mask_reg     <= cfg_wdata[7:0];
                ehas_pkg::CFG_OBF_MASK:     obf_mask_reg     <= cfg_wdata[7:0];
                ehas_pkg::CFG_TIMEOUT:      timeout_reg      <= cfg_wdata[15:0];
                ehas_pkg::CFG_TOGGLE_MASK:  toggle_mask_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Status poll evaluation
    assign want_set     = (phase_reg == PH_RD_OBF);
    assign poll_mask    = want_set ? obf_mask_reg : ibf_mask_reg;
    assign poll_met     = (((port_data & poll_mask) == poll_mask) == want_set);
    assign wait_expired = CMP_W'(wait_ticks_reg) >= CMP_W'(timeout_reg);

    assign in_xfer = s_tvalid && s_tready;

    // One step of the sequencer: next state and up to two results
    always_comb
    begin
        phase_next      = phase_reg;
        op_kind_next    = op_kind_reg;
        target_reg_next = target_reg_reg;
        pending_next    = pending_reg;
        fetched_next    = fetched_reg;
        wait_ticks_next = wait_ticks_reg;
        n_res           = 2'd0;
        run_new.res0    = mk_res(ehas_pkg::KIND_PORT_RD, command_port_reg, 8'd0, 8'd0,
                                 1'b0, ehas_pkg::ST_OK);
        run_new.res1    = run_new.res0;
        run_new.two     = 1'b0;

        priority if (req_type <= ehas_pkg::REQ_TEST)
        begin
            n_res = 2'd1;
            if (phase_reg != PH_IDLE)
            begin
                run_new.res0 = mk_res(ehas_pkg::KIND_DONE, 16'd0, 8'd0, 8'd0, 1'b0,
                                      ehas_pkg::ST_BUSY);
            end
            else
            begin
                op_kind_next    = req_type[1:0];
                target_reg_next = ec_reg;
                wait_ticks_next = '0;
                if (req_type == ehas_pkg::REQ_WRITE)
                begin
                    pending_next = write_value;
                    phase_next   = PH_WR_CMD;
                end
                else
                begin
                    phase_next = PH_RD_CMD;
                end
            end
        end
        else if (req_type == ehas_pkg::REQ_TICK)
        begin
            if (phase_reg != PH_IDLE && wait_ticks_reg != '1)
                wait_ticks_next = wait_ticks_reg + 1'b1;
        end
        else if (req_type != ehas_pkg::REQ_RESP || phase_reg == PH_IDLE)
        begin
            // unused codes, and responses while idle, are dropped
        end
        else if (bus_error)
        begin
            n_res        = 2'd1;
            phase_next   = PH_IDLE;
            run_new.res0 = mk_res(ehas_pkg::KIND_DONE, 16'd0, 8'd0, 8'd0, 1'b0,
                                  ehas_pkg::ST_BUS_ERR);
        end
        else if (phase_reg == PH_RD_DATA)
        begin
            // Data byte from the controller
            n_res        = 2'd1;
            fetched_next = port_data;
            unique case (op_kind_reg)
                ehas_pkg::OP_READ:
                begin
                    phase_next   = PH_IDLE;
                    run_new.res0 = mk_res(ehas_pkg::KIND_DONE, 16'd0, 8'd0, port_data,
                                          1'b0, ehas_pkg::ST_OK);
                end
                ehas_pkg::OP_TEST:
                begin
                    phase_next   = PH_IDLE;
                    run_new.res0 = mk_res(ehas_pkg::KIND_DONE, 16'd0, 8'd0, port_data,
                                          mask_set(port_data, toggle_mask_reg),
                                          ehas_pkg::ST_OK);
                end
                default:
                begin
                    // toggle: clear the masked bits if all are set, else set them; start the write-back
                    pending_next    = mask_set(port_data, toggle_mask_reg)
                                      ? (port_data & ~toggle_mask_reg)
                                      : (port_data | toggle_mask_reg);
                    phase_next      = PH_WR_CMD;
                    wait_ticks_next = '0;
                end
            endcase
        end
        else if (!poll_met)
        begin
            // Status not yet as wanted: poll again or give up
            n_res = 2'd1;
            if (wait_expired)
            begin
                phase_next   = PH_IDLE;
                run_new.res0 = mk_res(ehas_pkg::KIND_DONE, 16'd0, 8'd0, 8'd0, 1'b0,
                                      ehas_pkg::ST_TIMEOUT);
            end
        end
        else
        begin
            // Status met: advance the port sequence
            n_res = 2'd2;
            run_new.two = 1'b1;
            wait_ticks_next = '0;
            unique case (phase_reg)
                PH_RD_CMD:
                begin
                    run_new.res0 = mk_res(ehas_pkg::KIND_PORT_WR, command_port_reg,
                                          read_opcode_reg, 8'd0, 1'b0, ehas_pkg::ST_OK);
                    phase_next   = PH_RD_REG;
                end
                PH_RD_REG:
                begin
                    run_new.res0 = mk_res(ehas_pkg::KIND_PORT_WR, data_port_reg,
                                          target_reg_reg, 8'd0, 1'b0, ehas_pkg::ST_OK);
                    phase_next   = PH_RD_OBF;
                end
                PH_RD_OBF:
                begin
                    n_res           = 2'd1;
                    run_new.two     = 1'b0;
                    wait_ticks_next = wait_ticks_reg;
                    run_new.res0    = mk_res(ehas_pkg::KIND_PORT_RD, data_port_reg, 8'd0,
                                             8'd0, 1'b0, ehas_pkg::ST_OK);
                    phase_next      = PH_RD_DATA;
                end
                PH_WR_CMD:
                begin
                    run_new.res0 = mk_res(ehas_pkg::KIND_PORT_WR, command_port_reg,
                                          write_opcode_reg, 8'd0, 1'b0, ehas_pkg::ST_OK);
                    phase_next   = PH_WR_REG;
                end
                PH_WR_REG:
                begin
                    run_new.res0 = mk_res(ehas_pkg::KIND_PORT_WR, data_port_reg,
                                          target_reg_reg, 8'd0, 1'b0, ehas_pkg::ST_OK);
                    phase_next   = PH_WR_VAL;
                end
                default:
                begin
                    // final data write, then completion
                    wait_ticks_next = wait_ticks_reg;
                    run_new.res0    = mk_res(ehas_pkg::KIND_PORT_WR, data_port_reg,
                                             pending_reg, 8'd0, 1'b0, ehas_pkg::ST_OK);
                    phase_next      = PH_IDLE;
                    if (op_kind_reg == ehas_pkg::OP_TOGGLE)
                        run_new.res1 = mk_res(ehas_pkg::KIND_DONE, 16'd0, 8'd0, fetched_reg,
                                              !mask_set(fetched_reg, toggle_mask_reg),
                                              ehas_pkg::ST_OK);
                    else
                        run_new.res1 = mk_res(ehas_pkg::KIND_DONE, 16'd0, 8'd0, 8'd0,
                                              1'b0, ehas_pkg::ST_OK);
                end
            endcase
        end
    end

    // Sequence state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            op_kind_reg    <= ehas_pkg::OP_READ;
            target_reg_reg <= 8'd0;
            pending_reg    <= 8'd0;
            fetched_reg    <= 8'd0;
            wait_ticks_reg <= '0;
        end
        else if (in_xfer)
        begin
            phase_reg      <= phase_next;
            op_kind_reg    <= op_kind_next;
            target_reg_reg <= target_reg_next;
            pending_reg    <= pending_next;
            fetched_reg    <= fetched_next;
            wait_ticks_reg <= wait_ticks_next;
        end
    end

    // Run queue control
    assign s_tready  = (count_reg != 2'd2);
    assign push      = in_xfer && (n_res != 2'd0);
    assign m_tvalid  = (count_reg != 2'd0);
    assign head_res  = sub_reg ? run_q[rd_ptr_reg].res1 : run_q[rd_ptr_reg].res0;
    assign head_last = (sub_reg == run_q[rd_ptr_reg].two);
    assign pop       = m_tvalid && m_tready && head_last;

    always_ff @(posedge clk)
    begin
        if (push)
            run_q[wr_ptr_reg] <= run_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
            // step through the results of the head run
            if (m_tvalid && m_tready)
                sub_reg <= !head_last;
        end
    end

    // Output packing
    assign m_tuser = head_res.kind;
    assign m_tdata = {5'd0, head_res.status, head_res.bit_state, head_res.rval,
                      head_res.wdata, head_res.addr};
    assign m_tlast = head_last;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("run queue count out of range");

    a_sub_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (m_tvalid && run_q[rd_ptr_reg].two))
        else $error("second result selected from a single-result run");

    a_busy_reject_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && req_type <= ehas_pkg::REQ_TEST && phase_reg != PH_IDLE)
        |=> (phase_reg == $past(phase_reg)))
        else $error("rejected request changed the phase");

    a_start_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && req_type <= ehas_pkg::REQ_TEST && phase_reg == PH_IDLE)
        |=> (phase_reg != PH_IDLE && wait_ticks_reg == '0 && m_tvalid))
        else $error("request start did not arm a wait");

    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> (!s_tready && m_tvalid))
        else $error("input taken with a full run queue");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ec_host_access_sequencer_top: directed table, then
// state-aware random requests and controller responses under four register sets.
// Depends on ehas_pkg and the sequencer RTL; predicts every output transfer.
module testbench;

    // Request codes the sequencer must ignore
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;
    localparam int unsigned HOLD_CYCLES = 48;
    localparam int unsigned MAX_REPORTS = 10;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_RD_CMD, SQ_RD_REG, SQ_RD_OBF, SQ_RD_DATA,
        SQ_WR_CMD, SQ_WR_REG, SQ_WR_VAL
    } seq_phase_e;

    // One input transfer
    typedef struct packed {
        logic [2:0] req;
        logic [7:0] ec_reg;
        logic [7:0] wval;
        logic [7:0] pdata;
        logic       berr;
    } ec_item_t;

    // One output transfer
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  rval;
        logic        bit_state;
        logic [1:0]  status;
        logic        last;
    } ec_xfer_t;

    // Directed row; typed rows carry a hand-written single result
    typedef struct packed {
        ec_item_t item;
        logic     typed;
        ec_xfer_t xfer;
    } dir_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [ehas_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [ehas_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ehas_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic [ehas_pkg::S_TUSER_W-1:0]  s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ehas_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [ehas_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                            m_tlast;

    ec_host_access_sequencer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predicted register file
    logic [15:0] cmd_port_m, data_port_m, timeout_m;
    logic [7:0]  rd_op_m, wr_op_m, ibf_mask_m, obf_mask_m, tog_mask_m;

    // Predicted sequence state
    seq_phase_e                  ph_m;
    logic [1:0]                  op_m;
    logic [7:0]                  tgt_m, pend_m, fetched_m;
    logic [ehas_pkg::TICK_W-1:0] ticks_m;

    ec_xfer_t    run_q[$];
    ec_xfer_t    port_xfer_expect_q[$];
    dir_row_t    dir_tab[$];

    int unsigned tx_idle_pct, rx_idle_pct;
    int unsigned rx_hold_left;
    int unsigned burst_left;
    logic        miss_next;
    int unsigned fail_cnt, items_sent, xfers_seen;
    int unsigned done_by_status[4];

    // ---------------------------------------------------------------- predictor

    function automatic void add_xfer(logic [1:0] kind, logic [15:0] addr, logic [7:0] wdata,
                                     logic [7:0] rval, logic bit_state, logic [1:0] status);
        ec_xfer_t x;
        x.kind = kind;
        x.addr = addr;
        x.wdata = wdata;
        x.rval = rval;
        x.bit_state = bit_state;
        x.status = status;
        x.last = 1'b0;
        run_q.push_back(x);
    endfunction

    // Poll of the status port opens every wait
    function automatic void begin_wait(seq_phase_e nxt);
        ph_m = nxt;
        ticks_m = '0;
        add_xfer(ehas_pkg::KIND_PORT_RD, cmd_port_m, 8'h00, 8'h00, 1'b0, ehas_pkg::ST_OK);
    endfunction

    function automatic void complete_req(logic [1:0] st, logic [7:0] rval, logic bit_state);
        ph_m = SQ_IDLE;
        done_by_status[st]++;
        if (st != ehas_pkg::ST_OK)
        begin
            rval = 8'h00;
            bit_state = 1'b0;
        end
        add_xfer(ehas_pkg::KIND_DONE, 16'h0000, 8'h00, rval, bit_state, st);
    endfunction

    function automatic logic toggle_bits_set(logic [7:0] v);
        return (v & tog_mask_m) == tog_mask_m;
    endfunction

    // Status byte answering a wait
    function automatic void status_arrived(logic [7:0] st);
        logic       want;
        logic [7:0] m;
        want = (ph_m == SQ_RD_OBF);
        m = want ? obf_mask_m : ibf_mask_m;
        if (((st & m) == m) != want)
        begin
            if (ticks_m >= timeout_m)
                complete_req(ehas_pkg::ST_TIMEOUT, 8'h00, 1'b0);
            else
                add_xfer(ehas_pkg::KIND_PORT_RD, cmd_port_m, 8'h00, 8'h00, 1'b0,
                         ehas_pkg::ST_OK);
            return;
        end
        case (ph_m)
            SQ_RD_CMD:
            begin
                add_xfer(ehas_pkg::KIND_PORT_WR, cmd_port_m, rd_op_m, 8'h00, 1'b0,
                         ehas_pkg::ST_OK);
                begin_wait(SQ_RD_REG);
            end
            SQ_RD_REG:
            begin
                add_xfer(ehas_pkg::KIND_PORT_WR, data_port_m, tgt_m, 8'h00, 1'b0,
                         ehas_pkg::ST_OK);
                begin_wait(SQ_RD_OBF);
            end
            SQ_RD_OBF:
            begin
                ph_m = SQ_RD_DATA;
                add_xfer(ehas_pkg::KIND_PORT_RD, data_port_m, 8'h00, 8'h00, 1'b0,
                         ehas_pkg::ST_OK);
            end
            SQ_WR_CMD:
            begin
                add_xfer(ehas_pkg::KIND_PORT_WR, cmd_port_m, wr_op_m, 8'h00, 1'b0,
                         ehas_pkg::ST_OK);
                begin_wait(SQ_WR_REG);
            end
            SQ_WR_REG:
            begin
                add_xfer(ehas_pkg::KIND_PORT_WR, data_port_m, tgt_m, 8'h00, 1'b0,
                         ehas_pkg::ST_OK);
                begin_wait(SQ_WR_VAL);
            end
            default:
            begin
                add_xfer(ehas_pkg::KIND_PORT_WR, data_port_m, pend_m, 8'h00, 1'b0,
                         ehas_pkg::ST_OK);
                if (op_m == ehas_pkg::OP_TOGGLE)
                    complete_req(ehas_pkg::ST_OK, fetched_m, !toggle_bits_set(fetched_m));
                else
                    complete_req(ehas_pkg::ST_OK, 8'h00, 1'b0);
            end
        endcase
    endfunction

    // Controller data byte
    function automatic void data_arrived(logic [7:0] v);
        fetched_m = v;
        if (op_m == ehas_pkg::OP_READ)
            complete_req(ehas_pkg::ST_OK, v, 1'b0);
        else if (op_m == ehas_pkg::OP_TEST)
            complete_req(ehas_pkg::ST_OK, v, toggle_bits_set(v));
        else
        begin
            // toggle: clear the mask bits if all set, else set them
            pend_m = toggle_bits_set(v) ? (v & ~tog_mask_m) : (v | tog_mask_m);
            begin_wait(SQ_WR_CMD);
        end
    endfunction

    function automatic void sequencer_predict(ec_item_t it);
        if (it.req <= ehas_pkg::REQ_TEST)
        begin
            if (ph_m != SQ_IDLE)
            begin
                done_by_status[ehas_pkg::ST_BUSY]++;
                add_xfer(ehas_pkg::KIND_DONE, 16'h0000, 8'h00, 8'h00, 1'b0,
                         ehas_pkg::ST_BUSY);
            end
            else
            begin
                op_m = it.req[1:0];
                tgt_m = it.ec_reg;
                if (it.req == ehas_pkg::REQ_WRITE)
                    pend_m = it.wval;
                begin_wait((it.req == ehas_pkg::REQ_WRITE) ? SQ_WR_CMD : SQ_RD_CMD);
            end
        end
        else if (it.req == ehas_pkg::REQ_TICK)
        begin
            if (ph_m != SQ_IDLE && ticks_m != '1)
                ticks_m++;
        end
        else if (it.req == ehas_pkg::REQ_RESP && ph_m != SQ_IDLE)
        begin
            if (it.berr)
                complete_req(ehas_pkg::ST_BUS_ERR, 8'h00, 1'b0);
            else if (ph_m == SQ_RD_DATA)
                data_arrived(it.pdata);
            else
                status_arrived(it.pdata);
        end
    endfunction

    function automatic logic item_ignored(ec_item_t it);
        return (it.req > ehas_pkg::REQ_TICK) ||
               ((it.req == ehas_pkg::REQ_RESP || it.req == ehas_pkg::REQ_TICK) &&
                ph_m == SQ_IDLE);
    endfunction

    function automatic void model_reset();
        cmd_port_m = ehas_pkg::RST_COMMAND_PORT;
        data_port_m = ehas_pkg::RST_DATA_PORT;
        rd_op_m = ehas_pkg::RST_READ_OPCODE;
        wr_op_m = ehas_pkg::RST_WRITE_OPCODE;
        ibf_mask_m = ehas_pkg::RST_IBF_MASK;
        obf_mask_m = ehas_pkg::RST_OBF_MASK;
        timeout_m = ehas_pkg::RST_TIMEOUT;
        tog_mask_m = ehas_pkg::RST_TOGGLE_MASK;
        ph_m = SQ_IDLE;
        op_m = ehas_pkg::OP_READ;
        tgt_m = '0;
        pend_m = '0;
        fetched_m = '0;
        ticks_m = '0;
    endfunction

    function automatic void model_write_reg(logic [ehas_pkg::CFG_ADDR_W-1:0] idx,
                                            logic [15:0] v);
        case (idx)
            ehas_pkg::CFG_COMMAND_PORT: cmd_port_m = v;
            ehas_pkg::CFG_DATA_PORT:    data_port_m = v;
            ehas_pkg::CFG_READ_OPCODE:  rd_op_m = v[7:0];
            ehas_pkg::CFG_WRITE_OPCODE: wr_op_m = v[7:0];
            ehas_pkg::CFG_IBF_MASK:     ibf_mask_m = v[7:0];
            ehas_pkg::CFG_OBF_MASK:     obf_mask_m = v[7:0];
            ehas_pkg::CFG_TIMEOUT:      timeout_m = v;
            default:                    tog_mask_m = v[7:0];
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic ec_xfer_t xf(logic [1:0] kind, logic [15:0] addr, logic [7:0] rval,
                                    logic [1:0] status);
        ec_xfer_t x;
        x = '0;
        x.kind = kind;
        x.addr = addr;
        x.rval = rval;
        x.status = status;
        x.last = 1'b1;
        return x;
    endfunction

    function automatic dir_row_t drow(logic [2:0] req, logic [7:0] rg, logic [7:0] wv,
                                      logic [7:0] pd, logic be, logic typed = 1'b0,
                                      ec_xfer_t tx = '0);
        dir_row_t r;
        r.item.req = req;
        r.item.ec_reg = rg;
        r.item.wval = wv;
        r.item.pdata = pd;
        r.item.berr = be;
        r.typed = typed;
        r.xfer = tx;
        return r;
    endfunction

    // Status byte that meets (or misses) the current wait
    function automatic logic [7:0] status_byte(logic [7:0] v, logic meet);
        logic       want;
        logic [7:0] m;
        want = (ph_m == SQ_RD_OBF);
        m = want ? obf_mask_m : ibf_mask_m;
        if (ph_m == SQ_RD_DATA)
            return v;
        return (want == meet) ? (v | m) : (v & ~m);
    endfunction

    // Next random item, shaped by the predicted phase
    function automatic ec_item_t make_item();
        ec_item_t    it;
        int unsigned r;
        it.ec_reg = 8'($urandom_range(255));
        it.wval = 8'($urandom_range(255));
        it.pdata = 8'($urandom_range(255));
        it.berr = 1'($urandom_range(1));
        r = $urandom_range(99);
        if (burst_left > 0 && ph_m != SQ_IDLE)
        begin
            burst_left--;
            it.req = ehas_pkg::REQ_TICK;
        end
        else if (ph_m == SQ_IDLE)
        begin
            if (r < 84)
                it.req = 3'($urandom_range(3));
            else if (r < 89)
                it.req = ehas_pkg::REQ_TICK;
            else if (r < 94)
                it.req = ehas_pkg::REQ_RESP;
            else
                it.req = ($urandom_range(1) != 0) ? REQ_SPARE_6 : REQ_SPARE_7;
        end
        else
        begin
            it.req = ehas_pkg::REQ_RESP;
            it.berr = 1'b0;
            if (miss_next)
            begin
                miss_next = 1'b0;
                it.pdata = status_byte(it.pdata, 1'b0);
            end
            else if (r < 68)
                it.pdata = status_byte(it.pdata, 1'b1);
            else if (r < 80)
                ;   // raw status byte
            else if (r < 85)
                it.berr = 1'b1;
            else if (r < 90)
                it.req = 3'($urandom_range(3));
            else if (r < 95)
                it.req = ehas_pkg::REQ_TICK;
            else
            begin
                // with a short timeout, run the wait out, then miss once to force a timeout
                it.req = ehas_pkg::REQ_TICK;
                if (timeout_m < 16'd8)
                begin
                    burst_left = 32'(timeout_m);
                    miss_next = 1'b1;
                end
            end
        end
        return it;
    endfunction

    task automatic send_item(input ec_item_t it, input logic typed, input ec_xfer_t tx);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.req;
        s_tdata <= {{(ehas_pkg::S_TDATA_W-25){1'b0}}, it.berr, it.pdata, it.wval, it.ec_reg};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        // transfer taken at this edge
        sequencer_predict(it);
        if (typed)
            run_q[0] = tx;
        if (run_q.size() != 0)
            run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[i])
            port_xfer_expect_q.push_back(run_q[i]);
        run_q.delete();
        items_sent++;
    endtask

    // Stop sending and wait for every expected transfer, plus pipeline slack
    task automatic settle();
        s_tvalid <= 1'b0;
        while (port_xfer_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] cmd, input logic [15:0] dport,
                                input logic [7:0] rdop, input logic [7:0] wrop,
                                input logic [7:0] ibf, input logic [7:0] obf,
                                input logic [15:0] tmo, input logic [7:0] tog);
        logic [15:0] vals [8];
        vals[ehas_pkg::CFG_COMMAND_PORT] = cmd;
        vals[ehas_pkg::CFG_DATA_PORT] = dport;
        vals[ehas_pkg::CFG_READ_OPCODE] = {8'h00, rdop};
        vals[ehas_pkg::CFG_WRITE_OPCODE] = {8'h00, wrop};
        vals[ehas_pkg::CFG_IBF_MASK] = {8'h00, ibf};
        vals[ehas_pkg::CFG_OBF_MASK] = {8'h00, obf};
        vals[ehas_pkg::CFG_TIMEOUT] = tmo;
        vals[ehas_pkg::CFG_TOGGLE_MASK] = {8'h00, tog};
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= i[ehas_pkg::CFG_ADDR_W-1:0];
            cfg_wdata <= vals[i];
            @(posedge clk);
            model_write_reg(i[ehas_pkg::CFG_ADDR_W-1:0], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Random items; ignored ones do not count. hold_at/drain_at 0 = never
    task automatic run_random(input int unsigned n, input int unsigned hold_at,
                              input int unsigned drain_at);
        ec_item_t    it;
        int unsigned cnt;
        cnt = 0;
        burst_left = 0;
        miss_next = 1'b0;
        while (cnt < n)
        begin
            it = make_item();
            if (!item_ignored(it))
            begin
                cnt++;
                if (cnt == hold_at)
                    rx_hold_left = HOLD_CYCLES;
                if (cnt == drain_at)
                    settle();
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------- receiver

    // Random backpressure, with an occasional long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------- checker

    ec_xfer_t mon_got, mon_want;

    function automatic string xfer_text(ec_xfer_t x);
        return $sformatf("kind=%0d addr=%h wdata=%h rval=%h bit=%b st=%0d last=%b",
                         x.kind, x.addr, x.wdata, x.rval, x.bit_state, x.status, x.last);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            mon_got.kind = m_tuser;
            mon_got.addr = m_tdata[15:0];
            mon_got.wdata = m_tdata[23:16];
            mon_got.rval = m_tdata[31:24];
            mon_got.bit_state = m_tdata[32];
            mon_got.status = m_tdata[34:33];
            mon_got.last = m_tlast;
            xfers_seen++;
            if (port_xfer_expect_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected transfer %s", $realtime, xfer_text(mon_got));
            end
            else
            begin
                mon_want = port_xfer_expect_q.pop_front();
                if (mon_got.kind !== mon_want.kind || mon_got.addr !== mon_want.addr ||
                    mon_got.wdata !== mon_want.wdata || mon_got.rval !== mon_want.rval ||
                    mon_got.bit_state !== mon_want.bit_state ||
                    mon_got.status !== mon_want.status || mon_got.last !== mon_want.last)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch, expected %s", $realtime,
                                 xfer_text(mon_want));
                        $display("%0t:   actual   %s", $realtime, xfer_text(mon_got));
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        tx_idle_pct = 36;
        rx_idle_pct = 72;
        rx_hold_left = 0;
        fail_cnt = 0;
        items_sent = 0;
        xfers_seen = 0;
        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset register values
        dir_tab.push_back(drow(ehas_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 1'b0)); // tick, idle
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'hFF, 1'b1)); // resp, idle
        dir_tab.push_back(drow(REQ_SPARE_7, 8'hFF, 8'hFF, 8'hFF, 1'b1));        // unused code
        dir_tab.push_back(drow(ehas_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                               xf(ehas_pkg::KIND_PORT_RD, ehas_pkg::RST_COMMAND_PORT,
                                  8'h00, ehas_pkg::ST_OK)));
        dir_tab.push_back(drow(ehas_pkg::REQ_WRITE, 8'h3C, 8'hFF, 8'h00, 1'b0, 1'b1,
                               xf(ehas_pkg::KIND_DONE, 16'h0000, 8'h00, ehas_pkg::ST_BUSY)));
        // input buffer full, then empty
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h02, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'hFD, 1'b0));
        // output not ready, then ready
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h01, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1,
                               xf(ehas_pkg::KIND_DONE, 16'h0000, 8'hFF, ehas_pkg::ST_OK)));
        dir_tab.push_back(drow(ehas_pkg::REQ_TEST, 8'h5A, 8'h00, 8'h00, 1'b0, 1'b1,
                               xf(ehas_pkg::KIND_PORT_RD, ehas_pkg::RST_COMMAND_PORT,
                                  8'h00, ehas_pkg::ST_OK)));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                               xf(ehas_pkg::KIND_DONE, 16'h0000, 8'h00,
                                  ehas_pkg::ST_BUS_ERR)));
        // full toggle sequence
        dir_tab.push_back(drow(ehas_pkg::REQ_TOGGLE, 8'hFF, 8'h00, 8'h00, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h01, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        // full write sequence
        dir_tab.push_back(drow(ehas_pkg::REQ_WRITE, 8'h80, 8'hFF, 8'h00, 1'b0, 1'b1,
                               xf(ehas_pkg::KIND_PORT_RD, ehas_pkg::RST_COMMAND_PORT,
                                  8'h00, ehas_pkg::ST_OK)));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        dir_tab.push_back(drow(ehas_pkg::REQ_RESP, 8'h00, 8'h00, 8'h00, 1'b0));
        foreach (dir_tab[i])
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].xfer);
        settle();

        // Extreme register values, zero timeout, output mask empty; long receiver hold-off
        program_regs(16'hFFFF, 16'h0000, 8'hFF, 8'h00, 8'hFF, 8'h00, 16'h0000, 8'hFF);
        run_random(38, 20, 0);
        settle();

        // Extreme ports and opcodes flipped, longest timeout, empty toggle mask; one mid-run drain
        tx_idle_pct = 72;
        rx_idle_pct = 36;
        program_regs(16'h0000, 16'hFFFF, 8'h00, 8'hFF, 8'h01, 8'h80, 16'hFFFF, 8'h00);
        run_random(38, 0, 20);
        settle();

        // Random ports and masks, short timeout, full rate
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     16'd3, 8'($urandom_range(255)));
        run_random(22, 0, 0);
        settle();

        // Input-full mask empty: a wait for an empty buffer is never met, ends in timeout or bus error
        program_regs(16'h1234, 16'h00A5, 8'h80, 8'h81, 8'h00, 8'hFF, 16'd1, 8'h81);
        run_random(6, 0, 0);
        settle();

        $display("run covered %0d input and %0d output transfers under five register sets",
                 items_sent, xfers_seen);
        $display("completions: ok %0d, timeout %0d, bus error %0d, busy %0d; %0d failures",
                 done_by_status[ehas_pkg::ST_OK], done_by_status[ehas_pkg::ST_TIMEOUT],
                 done_by_status[ehas_pkg::ST_BUS_ERR], done_by_status[ehas_pkg::ST_BUSY],
                 fail_cnt);
        if (fail_cnt == 0)
            $display("PASS ec_host_access_sequencer_top");
        else
            $display("FAIL ec_host_access_sequencer_top");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("FAIL ec_host_access_sequencer_top");
        $finish;
    end

endmodule
